### rtl/ptlru_pkg.sv
// Shared constants and types for the paged address translator with LRU eviction.
// No dependencies; imported by the top level.
package ptlru_pkg;

   localparam int PAGE_OFFSET_BITS = 12;
   localparam int VIRTUAL_PAGES    = 256;
   localparam int FRAMES           = 16;
   localparam int TIME_BITS        = 32;

   localparam int PAGE_BITS  = $clog2(VIRTUAL_PAGES);
   localparam int FRAME_BITS = $clog2(FRAMES);

   localparam int ADDR_BITS      = 32;
   localparam int COUNT_BITS     = 32;
   localparam int PHYS_BITS      = 16;
   localparam int LOADED_BITS    = 4;
   localparam int VICTIM_BITS    = 8;
   localparam int RSP_DATA_BITS  = 96;

   // Sequencer states, one-hot.
   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_LOOKUP = 6'b000010,
      ST_HIT    = 6'b000100,
      ST_SCAN   = 6'b001000,
      ST_COMMIT = 6'b010000,
      ST_RESP   = 6'b100000
   } state_type;

   // One result item.
   typedef struct packed {
      logic                   addr_error;
      logic [PHYS_BITS-1:0]   phys_addr;
      logic                   page_fault;
      logic [LOADED_BITS-1:0] loaded_frame;
      logic                   evicted;
      logic [VICTIM_BITS-1:0] evict_page;
      logic                   victim_dirty;
      logic [COUNT_BITS-1:0]  fault_total;
      logic [COUNT_BITS-1:0]  disk_transfers;
   } result_type;

endpackage

### rtl/paged_translation_with_lru_eviction.sv
// Demand-paging address translator with least-recently-used frame replacement.
// Depends on ptlru_pkg for sizes, the sequencer state type and the result record.
//
// Usage:
//   The request channel (req_) carries one access per transaction: req_tdata holds the
//   signed 32-bit logical address and req_tuser the access kind (0 read, 1 write).
//   The response channel (rsp_) returns exactly one result per access: rsp_tuser is
//   the address error flag and rsp_tdata the translation and fault details.
//   The block works on one access at a time and holds req_tready low until the
//   current access has been handed to the response register.
// Path from the accepting edge to rsp_tvalid, by state:
//   an address error goes from IDLE through RESP; a resident page through LOOKUP,
//   HIT and RESP; a page fault through LOOKUP, SCAN, COMMIT and RESP. The frame
//   scan visits one frame per cycle through a single age subtractor and comparator,
//   and stops at the first free frame, so it examines at most FRAMES (16) frames.
//   A new access is accepted only once the previous one has left RESP for the
//   response register.
// Reset clears the residency and dirty flags, the frame occupancy, the access clock
//   and both running counters at once; no clearing pass is needed, and the first
//   access may be offered in the cycle after reset falls.
// A stalled receiver leaves the finished result in the response register; a further
//   finished result waits in the sequencer until that register has been taken.
module paged_translation_with_lru_eviction
   import ptlru_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // [31:0] virt_addr
   input  logic [ADDR_BITS-1:0]     req_tdata,
   // [0] op
   input  logic                     req_tuser,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // [15:0] phys_addr, [16] page_fault, [20:17] loaded_frame, [21] evicted,
   // [29:22] evict_page, [30] victim_dirty, [62:31] fault_total,
   // [94:63] disk_transfers, [95] zero
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   // [0] addr_error
   output logic                     rsp_tuser
);

   // Control state. The dirty flag of a resident page is kept with the frame it owns.
   state_type                  state_ff, state_in;
   logic [VIRTUAL_PAGES-1:0]   page_valid_ff, page_valid_in;
   logic [FRAMES-1:0]          frame_dirty_ff, frame_dirty_in;
   logic [FRAMES-1:0]          frame_used_ff, frame_used_in;
   logic [TIME_BITS-1:0]       clock_ff, clock_in;
   logic [COUNT_BITS-1:0]      fault_ff, fault_in;
   logic [COUNT_BITS-1:0]      transfer_ff, transfer_in;
   logic                       rsp_valid_ff, rsp_valid_in;

   // Payload and per-frame bookkeeping.
   logic [PAGE_BITS-1:0]        frame_owner_ff [FRAMES];
   logic [PAGE_BITS-1:0]        frame_owner_in [FRAMES];
   logic [TIME_BITS-1:0]        frame_use_ff   [FRAMES];
   logic [TIME_BITS-1:0]        frame_use_in   [FRAMES];
   logic                        op_ff, op_in;
   logic [PAGE_BITS-1:0]        page_ff, page_in;
   logic [PAGE_OFFSET_BITS-1:0] offset_ff, offset_in;
   logic [FRAME_BITS-1:0]       scan_idx_ff, scan_idx_in;
   logic                        free_found_ff, free_found_in;
   logic [FRAME_BITS-1:0]       free_idx_ff, free_idx_in;
   logic [FRAME_BITS-1:0]       best_idx_ff, best_idx_in;
   logic [TIME_BITS-1:0]        best_age_ff, best_age_in;
   result_type                  res_ff, res_in;
   result_type                  rsp_ff, rsp_in;

   // Page table: frame of each resident page. Entries are only read for
   // resident pages, which have always been written first.
   logic [FRAME_BITS-1:0]       page_frame_mem [VIRTUAL_PAGES];
   logic [FRAME_BITS-1:0]       pf_rd_ff;

   logic [ADDR_BITS-1:0]        addr_page;
   logic                        addr_bad;
   logic [TIME_BITS-1:0]        scan_age;
   logic [FRAME_BITS-1:0]       sel_frame;
   logic [PAGE_BITS-1:0]        evict_page;
   logic                        do_evict;
   logic                        victim_dirty;
   logic                        scan_last;

   // A negative address or a page number past the table is rejected.
   assign addr_page = req_tdata >> PAGE_OFFSET_BITS;
   assign addr_bad  = req_tdata[ADDR_BITS-1] || (addr_page >= ADDR_BITS'(VIRTUAL_PAGES));

   // The shared age unit: clock minus last use, modulo the clock width.
   assign scan_age  = clock_ff - frame_use_ff[scan_idx_ff];
   assign scan_last = (scan_idx_ff == FRAME_BITS'(FRAMES - 1));

   // Placement chosen by the scan: the lowest free frame if there is one,
   // otherwise the frame with the greatest age.
   assign do_evict     = !free_found_ff;
   assign sel_frame    = free_found_ff ? free_idx_ff : best_idx_ff;
   assign evict_page   = frame_owner_ff[best_idx_ff];
   assign victim_dirty = do_evict && frame_dirty_ff[best_idx_ff];

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.addr_error;
   assign rsp_tdata  = {1'b0, rsp_ff.disk_transfers, rsp_ff.fault_total, rsp_ff.victim_dirty,
                        rsp_ff.evict_page, rsp_ff.evicted, rsp_ff.loaded_frame,
                        rsp_ff.page_fault, rsp_ff.phys_addr};

   always_comb begin
      state_in       = state_ff;
      page_valid_in  = page_valid_ff;
      frame_dirty_in = frame_dirty_ff;
      frame_used_in  = frame_used_ff;
      clock_in       = clock_ff;
      fault_in       = fault_ff;
      transfer_in    = transfer_ff;
      frame_owner_in = frame_owner_ff;
      frame_use_in   = frame_use_ff;
      op_in          = op_ff;
      page_in        = page_ff;
      offset_in      = offset_ff;
      scan_idx_in    = scan_idx_ff;
      free_found_in  = free_found_ff;
      free_idx_in    = free_idx_ff;
      best_idx_in    = best_idx_ff;
      best_age_in    = best_age_ff;
      res_in         = res_ff;
      rsp_in         = rsp_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               op_in     = req_tuser;
               page_in   = PAGE_BITS'(addr_page);
               offset_in = req_tdata[PAGE_OFFSET_BITS-1:0];
               if (addr_bad) begin
                  // Rejected access: every other field is zero; the access clock, tables and counters stay.
                  res_in            = '0;
                  res_in.addr_error = 1'b1;
                  state_in          = ST_RESP;
               end else begin
                  clock_in = clock_ff + 1'b1;
                  state_in = ST_LOOKUP;
               end
            end
         end
         ST_LOOKUP: begin
            if (page_valid_ff[page_ff]) begin
               state_in = ST_HIT;
            end else begin
               scan_idx_in   = '0;
               free_found_in = 1'b0;
               state_in      = ST_SCAN;
            end
         end
         ST_HIT: begin
            frame_use_in[pf_rd_ff] = clock_ff;
            if (op_ff) begin
               frame_dirty_in[pf_rd_ff] = 1'b1;
            end
            res_in                = '0;
            res_in.phys_addr      = PHYS_BITS'({pf_rd_ff, offset_ff});
            res_in.fault_total    = fault_ff;
            res_in.disk_transfers = transfer_ff;
            state_in              = ST_RESP;
         end
         ST_SCAN: begin
            if (scan_idx_ff == '0 || scan_age > best_age_ff) begin
               best_idx_in = scan_idx_ff;
               best_age_in = scan_age;
            end
            if (!frame_used_ff[scan_idx_ff]) begin
               free_found_in = 1'b1;
               free_idx_in   = scan_idx_ff;
               state_in      = ST_COMMIT;
            end else if (scan_last) begin
               state_in = ST_COMMIT;
            end else begin
               scan_idx_in = scan_idx_ff + 1'b1;
            end
         end
         ST_COMMIT: begin
            if (do_evict) begin
               page_valid_in[evict_page] = 1'b0;
            end
            frame_owner_in[sel_frame] = page_ff;
            frame_used_in[sel_frame]  = 1'b1;
            frame_use_in[sel_frame]   = clock_ff;
            frame_dirty_in[sel_frame] = op_ff;
            page_valid_in[page_ff]    = 1'b1;
            fault_in                  = fault_ff + 1'b1;
            // One load, plus one writeback when the victim was modified.
            transfer_in = transfer_ff + COUNT_BITS'(1) + COUNT_BITS'(victim_dirty);

            res_in                = '0;
            res_in.phys_addr      = PHYS_BITS'({sel_frame, offset_ff});
            res_in.page_fault     = 1'b1;
            res_in.loaded_frame   = LOADED_BITS'(sel_frame);
            res_in.evicted        = do_evict;
            res_in.evict_page     = do_evict ? VICTIM_BITS'(evict_page) : '0;
            res_in.victim_dirty   = victim_dirty;
            res_in.fault_total    = fault_in;
            res_in.disk_transfers = transfer_in;
            state_in              = ST_COMMIT == state_ff ? ST_RESP : state_ff;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         page_valid_ff  <= '0;
         frame_dirty_ff <= '0;
         frame_used_ff  <= '0;
         clock_ff       <= '0;
         fault_ff       <= '0;
         transfer_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         page_valid_ff  <= page_valid_in;
         frame_dirty_ff <= frame_dirty_in;
         frame_used_ff  <= frame_used_in;
         clock_ff       <= clock_in;
         fault_ff       <= fault_in;
         transfer_ff    <= transfer_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      frame_owner_ff <= frame_owner_in;
      frame_use_ff   <= frame_use_in;
      op_ff          <= op_in;
      page_ff        <= page_in;
      offset_ff      <= offset_in;
      scan_idx_ff    <= scan_idx_in;
      free_found_ff  <= free_found_in;
      free_idx_ff    <= free_idx_in;
      best_idx_ff    <= best_idx_in;
      best_age_ff    <= best_age_in;
      res_ff         <= res_in;
      rsp_ff         <= rsp_in;
   end

   // Page table memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (state_ff == ST_COMMIT) begin
         page_frame_mem[page_ff] <= sel_frame;
      end
      pf_rd_ff <= page_frame_mem[page_ff];
   end

`ifndef SYNTH
   // Every resident page owns exactly one occupied frame.
   a_resident_matches_frames: assert property (@(posedge clock) disable iff (reset)
      $countones(page_valid_ff) == $countones(frame_used_ff))
      else $error("resident page count differs from occupied frame count");

   // Frames are never released for good: an eviction refills the same frame.
   a_frames_never_shrink: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> $countones(frame_used_ff) >= $past($countones(frame_used_ff)))
      else $error("occupied frame count fell");

   // A fault bumps the fault counter by exactly one.
   a_fault_count_step: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_COMMIT |=> fault_ff == $past(fault_ff) + 1'b1)
      else $error("fault counter did not advance by one");

   // The scan walks the frames in order until it finds a free one or reaches the end.
   a_scan_walks_in_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN && frame_used_ff[scan_idx_ff] && !scan_last
      |=> state_ff == ST_SCAN && scan_idx_ff == $past(scan_idx_ff) + 1'b1)
      else $error("frame scan skipped or stopped early");

   // A rejected access carries nothing but the error flag.
   a_error_result_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.addr_error |-> rsp_tdata == '0)
      else $error("error response carries non-zero fields");
`endif

endmodule
